// ===== rtl/core/cpsa_pkg.sv =====
`default_nettype none

package cpsa_pkg;

   // Field widths
   localparam int DELAY_W     = 16;
   localparam int SPEED_W     = 24;
   localparam int CONST_W     = 24;

   // Packed stream words, padded to whole bytes
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 48;

   // Saturation limit of a speed magnitude
   localparam int SPEED_MAX   = 8388607;

   // Reset value of the speed constant
   localparam logic [CONST_W-1:0] CONST_RESET = 24'd25000;

   // Default ring depth
   localparam int FILTER_DEPTH_DEF = 8;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_RAW,
      ST_WRITE,
      ST_SUM,
      ST_DIV_AVG,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/cpsa_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module cpsa_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/commutation_period_speed_average_unit.sv =====
`default_nettype none

// Channel   Direction  Word fields (lowest bit first)
// req_*     in         delay_ticks[15:0], reverse[16], closed_loop[17], zero pad [23:18]
// rsp_*     out        speed_raw[23:0], speed_avg[47:24]
// csr_*     in         speed_constant[23:0], written when csr_wr_en is high
//
// One word at a time. Each word takes two passes of the shared one-bit-per-cycle
// restoring divider, DIV_W = 24 + clog2(FILTER_DEPTH+1) bits wide (28 at the default
// depth), with one ring read per entry summed between them. The next word is taken
// while a result still waits in the output register.
// Synchronous reset clears the ring at once through per-entry valid bits.
module commutation_period_speed_average_unit #(
   parameter int FILTER_DEPTH = cpsa_pkg::FILTER_DEPTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   // delay_ticks[15:0], reverse[16], closed_loop[17]
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [cpsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   // speed_raw[23:0], speed_avg[47:24]
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [cpsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                                csr_wr_en,
   input  wire  [cpsa_pkg::CONST_W-1:0]       csr_wr_data
);

   localparam int IDX_W  = $clog2(FILTER_DEPTH);
   localparam int CNT_W  = $clog2(FILTER_DEPTH + 1);
   localparam int SUM_W  = cpsa_pkg::SPEED_W + CNT_W;
   localparam int DIV_W  = SUM_W;
   localparam int DVR_W  = cpsa_pkg::DELAY_W;
   localparam int ITER_W = $clog2(DIV_W + 1);
   localparam int SW     = cpsa_pkg::SPEED_W;

   cpsa_pkg::state_type state_ff, state_in;

   logic [cpsa_pkg::CONST_W-1:0] const_ff;
   logic [IDX_W-1:0]             slot_ff, slot_in;
   logic [FILTER_DEPTH-1:0]      valid_ff, valid_in;
   logic                         rev_ff, rev_in;
   logic                         closed_ff, closed_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [CNT_W-1:0]             iss_ff, iss_in;
   logic                         pend_ff, pend_in;
   logic                         hit_ff, hit_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [SW-1:0]                raw_ff, raw_in;
   logic                         neg_ff, neg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cpsa_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared divider registers
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVR_W-1:0]  rem_ff, rem_in;
   logic [DVR_W-1:0]  dvr_ff, dvr_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   // RAM ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [SW-1:0]    wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [SW-1:0]    rd_data;

   // divider step
   logic [DVR_W:0]   rem_sh;
   logic             rem_ge;
   logic [DVR_W:0]   rem_sub;
   logic [DIV_W-1:0] quo_step;
   logic [DVR_W-1:0] rem_step;

   // write stage helpers
   logic             sat;
   logic [SW-1:0]    mag;
   logic [IDX_W-1:0] slot_nx;
   logic [SUM_W-1:0] sum_abs;
   logic [SW-1:0]    avg;

   cpsa_ram #(
      .WIDTH (SW),
      .DEPTH (FILTER_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == cpsa_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one restoring division step
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
      rem_ge   = (rem_sh >= {1'b0, dvr_ff});
      rem_sub  = rem_sh - {1'b0, dvr_ff};
      rem_step = rem_ge ? rem_sub[DVR_W-1:0] : rem_sh[DVR_W-1:0];
      quo_step = {quo_ff[DIV_W-2:0], rem_ge};
   end

   // raw speed magnitude from quotient, saturated; next slot, sum magnitude, signed average
   always_comb begin
      sat     = (dvr_ff == '0) || (quo_ff > DIV_W'(cpsa_pkg::SPEED_MAX));
      mag     = sat ? SW'(cpsa_pkg::SPEED_MAX) : quo_ff[SW-1:0];
      slot_nx = (slot_ff == IDX_W'(FILTER_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      avg     = neg_ff ? SW'(-quo_step) : quo_step[SW-1:0];
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         const_ff     <= cpsa_pkg::CONST_RESET;
         slot_ff      <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            const_ff <= csr_wr_data;
         end
         slot_ff      <= slot_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rev_ff      <= rev_in;
      closed_ff   <= closed_in;
      cnt_ff      <= cnt_in;
      iss_ff      <= iss_in;
      hit_ff      <= hit_in;
      sum_ff      <= sum_in;
      raw_ff      <= raw_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvr_ff      <= dvr_in;
      iter_ff     <= iter_in;
   end

   // sequencer: next state and datapath
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      valid_in     = valid_ff;
      rev_in       = rev_ff;
      closed_in    = closed_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      pend_in      = 1'b0;
      hit_in       = hit_ff;
      sum_in       = sum_ff;
      raw_in       = raw_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvr_in       = dvr_ff;
      iter_in      = iter_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = raw_ff;
      rd_en        = 1'b0;
      rd_addr      = iss_ff[IDX_W-1:0];

      // result taken downstream
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         cpsa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // speed_constant / delay_ticks
               rev_in    = req_tdata[DVR_W];
               closed_in = req_tdata[DVR_W+1];
               quo_in    = DIV_W'(const_ff);
               rem_in    = '0;
               dvr_in    = req_tdata[DVR_W-1:0];
               iter_in   = ITER_W'(DIV_W);
               state_in  = cpsa_pkg::ST_DIV_RAW;
            end
         end

         cpsa_pkg::ST_DIV_RAW: begin
            quo_in  = quo_step;
            rem_in  = rem_step;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               state_in = cpsa_pkg::ST_WRITE;
            end
         end

         cpsa_pkg::ST_WRITE: begin
            // store raw speed, advance slot, pick entry count
            raw_in            = rev_ff ? SW'(-mag) : mag;
            wr_en             = 1'b1;
            wr_data           = rev_ff ? SW'(-mag) : mag;
            valid_in[slot_ff] = 1'b1;
            slot_in           = slot_nx;
            if (closed_ff || (slot_nx == '0)) begin
               cnt_in = CNT_W'(FILTER_DEPTH);
            end else begin
               cnt_in = CNT_W'(slot_nx);
            end
            iss_in   = '0;
            sum_in   = '0;
            state_in = cpsa_pkg::ST_SUM;
         end

         cpsa_pkg::ST_SUM: begin
            // one read issued per cycle, accumulated in the cycle after it is issued
            if (iss_ff != cnt_ff) begin
               rd_en   = 1'b1;
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
               hit_in  = valid_ff[iss_ff[IDX_W-1:0]];
            end
            if (pend_ff && hit_ff) begin
               sum_in = sum_ff + SUM_W'(signed'(rd_data));
            end
            if ((iss_ff == cnt_ff) && !pend_ff) begin
               neg_in   = sum_ff[SUM_W-1];
               quo_in   = sum_abs;
               rem_in   = '0;
               dvr_in   = DVR_W'(cnt_ff);
               iter_in  = ITER_W'(DIV_W);
               state_in = cpsa_pkg::ST_DIV_AVG;
            end
         end

         cpsa_pkg::ST_DIV_AVG: begin
            quo_in  = quo_step;
            rem_in  = rem_step;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               // quotient complete this step; average high, raw speed low
               rsp_data_in[cpsa_pkg::RSP_DATA_W-1:SW] = avg;
               rsp_data_in[SW-1:0]                    = raw_ff;
               state_in = cpsa_pkg::ST_OUT;
            end
         end

         cpsa_pkg::ST_OUT: begin
            // the parked word waits in quo_ff and raw_ff; present it once the output is free
            rsp_data_in = rsp_data_ff;
            state_in    = cpsa_pkg::ST_OUT;
         end

         default: begin
            state_in = cpsa_pkg::ST_IDLE;
         end
      endcase

      // output register hand-off
      if (state_ff == cpsa_pkg::ST_DIV_AVG && iter_ff == ITER_W'(1)) begin
         if (rsp_valid_ff && !rsp_tready) begin
            // old word still waiting: keep it, park the new one
            rsp_data_in = rsp_data_ff;
            state_in    = cpsa_pkg::ST_OUT;
            raw_in      = raw_ff;
            quo_in      = {{(DIV_W-SW){1'b0}}, avg};
         end else begin
            rsp_valid_in = 1'b1;
            state_in     = cpsa_pkg::ST_IDLE;
         end
      end
      if (state_ff == cpsa_pkg::ST_OUT) begin
         if (!rsp_valid_ff || rsp_tready) begin
            rsp_data_in  = {quo_ff[SW-1:0], raw_ff};
            rsp_valid_in = 1'b1;
            state_in     = cpsa_pkg::ST_IDLE;
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/speed_average_checker.sv =====
`default_nettype none

// Watches the request, response and register ports of the speed unit, keeps its own
// copy of the ring and speed constant, and compares every response word in order.
module speed_average_checker #(
   parameter int DEPTH = cpsa_pkg::FILTER_DEPTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   input  wire                              req_tready,
   input  wire  [cpsa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                              rsp_tvalid,
   input  wire                              rsp_tready,
   input  wire  [cpsa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire                              csr_wr_en,
   input  wire  [cpsa_pkg::CONST_W-1:0]     csr_wr_data,
   output int                               words_pending,
   output int                               fail_count
);

   // Field order matches the response word: raw speed in the low half
   typedef struct packed {
      logic signed [cpsa_pkg::SPEED_W-1:0] avg;
      logic signed [cpsa_pkg::SPEED_W-1:0] raw;
   } speed_pair_type;

   logic signed [cpsa_pkg::SPEED_W-1:0] speed_hist [DEPTH];
   int                                  next_slot;
   logic [cpsa_pkg::CONST_W-1:0]        rpm_ticks;
   speed_pair_type                      expected_speeds [$];

   initial begin
      fail_count    = 0;
      words_pending = 0;
   end

   // One line per mismatch, and count it
   task automatic report_mismatch(input string what,
                                  input logic [cpsa_pkg::SPEED_W-1:0] want,
                                  input logic [cpsa_pkg::SPEED_W-1:0] got);
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what,
               $signed(want), $signed(got));
      fail_count++;
   endtask

   // Raw speed from one interval, then push into the ring and average
   function automatic speed_pair_type predict_speeds(
      input logic [cpsa_pkg::DELAY_W-1:0] delay, input logic rev, input logic closed);
      int unsigned     quot;
      int              mag;
      int              raw;
      int              n;
      longint          total;
      longint          avg;
      speed_pair_type  res;
      if (delay == '0) begin
         mag = cpsa_pkg::SPEED_MAX;
      end else begin
         quot = rpm_ticks / delay;
         mag  = (quot > cpsa_pkg::SPEED_MAX) ? cpsa_pkg::SPEED_MAX : int'(quot);
      end
      raw = rev ? -mag : mag;
      speed_hist[next_slot] = raw[cpsa_pkg::SPEED_W-1:0];
      next_slot = (next_slot == DEPTH-1) ? 0 : next_slot + 1;
      // open loop averages the slots filled since the last wrap; a wrap means full
      n = (closed || next_slot == 0) ? DEPTH : next_slot;
      total = 0;
      for (int i = 0; i < n; i++)
         total += speed_hist[i];
      avg = total / n;
      res.raw = raw[cpsa_pkg::SPEED_W-1:0];
      res.avg = avg[cpsa_pkg::SPEED_W-1:0];
      return res;
   endfunction

   // Sample every port at the rising edge
   always @(posedge clock) begin
      speed_pair_type want;
      speed_pair_type got;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++)
            speed_hist[i] = '0;
         next_slot = 0;
         rpm_ticks = cpsa_pkg::CONST_RESET;
         expected_speeds.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_speeds.size() == 0) begin
               report_mismatch("unexpected speed word", '0, got.raw);
            end else begin
               want = expected_speeds.pop_front();
               if (got.raw !== want.raw)
                  report_mismatch("speed_raw", want.raw, got.raw);
               if (got.avg !== want.avg)
                  report_mismatch("speed_avg", want.avg, got.avg);
            end
         end
         if (csr_wr_en)
            rpm_ticks = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_speeds.push_back(predict_speeds(req_tdata[15:0], req_tdata[16],
                                                     req_tdata[17]));
      end
      words_pending = expected_speeds.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

   localparam int CYCLE_LIMIT   = 1000000;
   // two divider passes, a full ring sum and overhead, with margin
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASES        = 10;
   localparam int RANDOM_WORDS  = 200;
   localparam int DLY_W         = cpsa_pkg::DELAY_W;
   localparam int CST_W         = cpsa_pkg::CONST_W;
   localparam int REQ_W         = cpsa_pkg::REQ_DATA_W;

   logic                              clock       = 1'b0;
   logic                              reset       = 1'b1;
   logic                              req_tvalid  = 1'b0;
   logic                              req_tready;
   logic [cpsa_pkg::REQ_DATA_W-1:0]   req_tdata   = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready  = 1'b0;
   logic [cpsa_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_wr_en   = 1'b0;
   logic [cpsa_pkg::CONST_W-1:0]      csr_wr_data = '0;

   int words_pending;
   int fail_count;
   int cycle_count = 0;
   int burst_left  = 0;
   int ready_mode  = 0;
   int mode_left   = 0;

   commutation_period_speed_average_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   speed_average_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .words_pending (words_pending),
      .fail_count    (fail_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Response back-pressure: a new mode every so often
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(16, 200);
      end else begin
         mode_left  <= mode_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 5) == 0);
         default: rsp_tready <= ((cycle_count % 16) < 8);
      endcase
   end

   // Offer one request word; bursts with random gaps in between
   task automatic send_word(input logic [cpsa_pkg::DELAY_W-1:0] delay, input logic rev,
                            input logic closed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_W'($urandom);
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, closed, rev, delay};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_constant(input logic [cpsa_pkg::CONST_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stop offering, let every response come back, then let the unit settle
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (words_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int                           closed_bias;
      logic [cpsa_pkg::DELAY_W-1:0] delay;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         // speed constant for this phase; phase 0 runs on the reset value
         case (phase)
            0: ;
            1: write_constant('1);
            2: write_constant(CST_W'(1));
            3: write_constant(CST_W'(0));
            PHASES-1: write_constant(cpsa_pkg::CONST_RESET);
            default: write_constant(CST_W'($urandom_range(0, 1) ? $urandom_range(1, 70000)
                                                  : $urandom_range(1, 24'hFFFFFF)));
         endcase

         // directed words
         case (phase)
            0: begin
               send_word(16'd0, 1'b0, 1'b0);        // zero interval, forward
               send_word(16'd0, 1'b1, 1'b0);        // zero interval, reverse
               send_word(16'd1, 1'b0, 1'b0);
               send_word(16'hFFFF, 1'b0, 1'b0);
               send_word(16'h5555, 1'b1, 1'b0);
               send_word(16'hAAAA, 1'b0, 1'b0);
               send_word(16'd12, 1'b0, 1'b0);
               send_word(16'd7, 1'b1, 1'b0);        // slot wraps: open loop on full ring
               send_word(16'd100, 1'b0, 1'b0);
               send_word(16'd3, 1'b0, 1'b1);
               send_word(16'd2, 1'b1, 1'b1);
               send_word(16'd0, 1'b0, 1'b1);
            end
            1: begin
               send_word(16'd1, 1'b0, 1'b0);        // quotient far above the limit
               send_word(16'd2, 1'b1, 1'b0);        // quotient exactly at the limit
               send_word(16'd3, 1'b0, 1'b1);
            end
            2: begin
               send_word(16'd1, 1'b1, 1'b0);
               send_word(16'd2, 1'b0, 1'b1);
            end
            3: begin
               send_word(16'd5, 1'b0, 1'b0);        // zero constant gives zero speed
               send_word(16'd0, 1'b1, 1'b1);        // but a zero interval still saturates
            end
            default: ;
         endcase

         // random words, loop mode biased per phase
         closed_bias = $urandom_range(0, 4);
         for (int i = 0; i < RANDOM_WORDS; i++) begin
            case ($urandom_range(0, 9))
               0:       delay = '0;
               1, 2:    delay = DLY_W'($urandom_range(1, 16));
               3:       delay = DLY_W'($urandom_range(1, 512));
               default: delay = DLY_W'($urandom_range(0, 65535));
            endcase
            send_word(delay, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) < closed_bias));
         end
         drain();
      end

      if (fail_count == 0 && words_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== commutation_period_speed_average_unit.f =====
rtl/core/cpsa_pkg.sv
rtl/core/cpsa_ram.sv
rtl/core/commutation_period_speed_average_unit.sv
tb/speed_average_checker.sv
tb/tb_top.sv
